>>> hdl/kwr_pkg.sv
// ----------------------------------------------------------------------------
// kwr_pkg: shared types for the k weakest rows selector
// Payload structs for both channels and the item passed from front to back.
// ----------------------------------------------------------------------------
package kwr_pkg;

    localparam int ROW_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 6;
    localparam int RC_W  = 7;

    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic             last_row;
    } kwr_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [CNT_W-1:0] soldier_total;
        logic             final_result;
        logic             rows_dropped;
    } kwr_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] soldiers;
        logic             last_row;
    } kwr_item_t;

    typedef struct packed {
        logic      valid;
        kwr_item_t item;
    } kwr_q_head_t;

endpackage

>>> hdl/kwr_front.sv
// ----------------------------------------------------------------------------
// kwr_front: input stage
// Accepts a row, counts its soldiers and pushes the result into the queue.
// ----------------------------------------------------------------------------
module kwr_front #(
    parameter int COLS = 32
) (
    input  logic              start,
    input  kwr_pkg::kwr_in_t  item,
    input  logic              q_full,
    output logic              busy,
    output logic              push,
    output kwr_pkg::kwr_item_t push_item
);
    import kwr_pkg::*;

    logic [ROW_W-1:0] col_mask;
    logic [ROW_W-1:0] masked;
    logic [3:0]       byte_sum [4];

    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            col_mask[j] = (j < COLS);
        end
        masked = item.row_bits & col_mask;
        for (int b = 0; b < 4; b++)
        begin
            byte_sum[b] = '0;
            for (int j = 0; j < 8; j++)
            begin
                byte_sum[b] = byte_sum[b] + 4'(masked[8*b+j]);
            end
        end
    end

    assign busy                = q_full;
    assign push                = start && !q_full;
    assign push_item.soldiers  = (CNT_W'(byte_sum[0]) + CNT_W'(byte_sum[1]))
                               + (CNT_W'(byte_sum[2]) + CNT_W'(byte_sum[3]));
    assign push_item.last_row  = item.last_row;

endmodule

>>> hdl/kwr_queue.sv
// ----------------------------------------------------------------------------
// kwr_queue: short item queue
// Holds counted rows between the front and the back so each can stall alone.
// ----------------------------------------------------------------------------
module kwr_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kwr_pkg::kwr_item_t   push_item,
    input  logic                 pop,
    output logic                 full,
    output kwr_pkg::kwr_q_head_t head
);
    import kwr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kwr_item_t         entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    logic              do_pop;

    assign full       = (fill_reg == CW'(DEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/kwr_back.sv
// ----------------------------------------------------------------------------
// kwr_back: ranking chain and report sequencer
// Inserts each row into a sorted chain of cells and, after the last row of a
// matrix, shifts the weakest rows out one per cycle.
// ----------------------------------------------------------------------------
module kwr_back #(
    parameter int ROWS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kwr_pkg::kwr_q_head_t head,
    input  logic [kwr_pkg::RC_W-1:0] report_count,
    output logic                 pop,
    output logic                 result_strobe,
    output kwr_pkg::kwr_out_t    result
);
    import kwr_pkg::*;

    localparam int HW = $clog2(ROWS + 1);

    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_REPORT = 2'b10
    } back_state_t;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [HW-1:0]    held_reg;
    logic [HW-1:0]    held_next;
    logic [HW-1:0]    held_after;
    logic             ovf_reg;
    logic             ovf_next;
    logic [RC_W-1:0]  rem_reg;
    logic [RC_W-1:0]  rem_next;
    logic [RC_W-1:0]  n_report;
    logic [CNT_W-1:0] cnt_reg  [ROWS];
    logic [CNT_W-1:0] cnt_next [ROWS];
    logic [IDX_W-1:0] idx_reg  [ROWS];
    logic [IDX_W-1:0] idx_next [ROWS];
    logic [ROWS-1:0]  heavier;
    logic             has_room;
    logic             out_valid_reg;
    logic             out_valid_next;
    kwr_out_t         out_data_reg;
    kwr_out_t         out_data_next;

    assign pop           = (state_reg == ST_RUN) && head.valid;
    assign has_room      = (held_reg < HW'(ROWS));
    assign held_after    = has_room ? held_reg + 1'b1 : held_reg;
    assign n_report      = (report_count < RC_W'(held_after)) ? report_count
                                                               : RC_W'(held_after);
    assign result_strobe = out_valid_reg;
    assign result        = out_data_reg;

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            heavier[i] = (held_reg > HW'(i)) && (cnt_reg[i] > head.item.soldiers);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        ovf_next       = ovf_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = 1'b0;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (pop)
                begin
                    if (has_room)
                    begin
                        for (int i = 0; i < ROWS; i++)
                        begin
                            if (i > 0 && heavier[(i > 0) ? i - 1 : 0])
                            begin
                                cnt_next[i] = cnt_reg[(i > 0) ? i - 1 : 0];
                                idx_next[i] = idx_reg[(i > 0) ? i - 1 : 0];
                            end
                            else if (heavier[i] || held_reg == HW'(i))
                            begin
                                cnt_next[i] = head.item.soldiers;
                                idx_next[i] = IDX_W'(held_reg);
                            end
                        end
                        held_next = held_after;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (head.item.last_row)
                    begin
                        if (n_report == '0)
                        begin
                            held_next = '0;
                            ovf_next  = 1'b0;
                        end
                        else
                        begin
                            rem_next   = n_report;
                            state_next = ST_REPORT;
                        end
                    end
                end
            end
            ST_REPORT:
            begin
                out_valid_next              = 1'b1;
                out_data_next.row_index     = idx_reg[0];
                out_data_next.soldier_total = cnt_reg[0];
                out_data_next.final_result  = (rem_reg == RC_W'(1));
                out_data_next.rows_dropped  = ovf_reg;
                for (int i = 0; i < ROWS - 1; i++)
                begin
                    cnt_next[i] = cnt_reg[i+1];
                    idx_next[i] = idx_reg[i+1];
                end
                rem_next = rem_reg - 1'b1;
                if (rem_reg == RC_W'(1))
                begin
                    state_next = ST_RUN;
                    held_next  = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            held_reg      <= '0;
            ovf_reg       <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            ovf_reg       <= ovf_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

    held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(ROWS))
        else $error("Held row count exceeds the chain length.");

    report_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPORT |-> rem_reg != '0)
        else $error("Report state entered with nothing to report.");

    final_closes_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.final_result |->
            state_reg == ST_RUN && held_reg == '0 && !ovf_reg)
        else $error("Matrix not closed after the final result.");

    no_pop_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_RUN)
        else $error("Queue popped during a report.");

endmodule

>>> hdl/k_weakest_rows_select.sv
// ----------------------------------------------------------------------------
// k_weakest_rows_select: top-k weakest rows of a streamed bit matrix
// Counts soldiers per row, ranks rows in a sorted cell chain and reports the
// weakest rows with their counts after the last row of each matrix.
//
//   channel   direction  handshake             payload
//   item      in         start, busy           kwr_in_t (row_bits, last_row)
//   result    out        result_strobe         kwr_out_t
//   cfg       in         cfg_valid, cfg_ready  report_count (7 bits)
//
// A row is taken in any cycle while the two-entry queue has room; the ranking
// chain retires one queued row per cycle except during a report, so rows
// stream at one per cycle. After a row marked last, the chain shifts out
// min(report_count, rows held) results on consecutive cycles, during which
// the queue may fill and raise busy. Results come from the report state.
// Reset clears the queue, row count and flags; report_count returns to 1.
// Results cannot be stalled; each is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module k_weakest_rows_select #(
    parameter int ROWS        = 64,
    parameter int COLS        = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  kwr_pkg::kwr_in_t              item,
    output logic                          result_strobe,
    output kwr_pkg::kwr_out_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kwr_pkg::RC_W-1:0]      cfg_data
);
    import kwr_pkg::*;

    logic              q_full;
    logic              push;
    kwr_item_t         push_item;
    logic              pop;
    kwr_q_head_t       head;
    logic [RC_W-1:0]   report_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_count_reg <= RC_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            report_count_reg <= cfg_data;
        end
    end

    kwr_front #(
        .COLS (COLS)
    ) u_front (
        .start     (start),
        .item      (item),
        .q_full    (q_full),
        .busy      (busy),
        .push      (push),
        .push_item (push_item)
    );

    kwr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    kwr_back #(
        .ROWS (ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .report_count  (report_count_reg),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

>>> verif/k_weakest_rows_select_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_weakest_rows_select_tb: self-checking testbench for the k weakest rows
// selector
// Streams bit-matrix rows through the start/busy command port. It changes the
// report size between matrices and predicts the ranked report of every
// matrix. Each strobed result is checked field by field, in order. A short
// table of hand-picked rows comes first, then random matrices under three
// sender idling profiles. The random matrices include ones that overflow the
// row store.
// ----------------------------------------------------------------------------
module k_weakest_rows_select_tb;

    import kwr_pkg::*;

    localparam int STORE_ROWS   = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ROWS   = 20;

    typedef enum logic [0:0] {
        STEP_ROW,
        STEP_CFG
    } step_kind_t;

    typedef struct packed {
        step_kind_t      kind;
        logic [RC_W-1:0] count;
        logic [31:0]     bits;
        logic            last;
        logic            pinned;
        kwr_out_t        pin;
    } step_t;

    typedef struct {
        kwr_out_t want;
        logic     pinned;
        kwr_out_t pin;
    } due_t;

    localparam kwr_out_t NO_PIN = '0;

    localparam step_t DIRECTED [22] = '{
        '{STEP_ROW, 7'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, '{6'd0, 6'd32, 1'b1, 1'b0}},
        '{STEP_ROW, 7'd0,  32'h0000_0000, 1'b1, 1'b1, '{6'd0, 6'd0, 1'b1, 1'b0}},
        '{STEP_CFG, 7'd64, 32'h0000_0000, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_0001, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h8000_0000, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'hAAAA_AAAA, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h5555_5555, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'hFFFF_0000, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_0000, 1'b1, 1'b0, NO_PIN},
        '{STEP_CFG, 7'd0,  32'h0000_0000, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h1234_5678, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_FFFF, 1'b1, 1'b0, NO_PIN},
        '{STEP_CFG, 7'd1,  32'h0000_0000, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_000F, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_0003, 1'b1, 1'b1, '{6'd1, 6'd2, 1'b1, 1'b0}},
        '{STEP_CFG, 7'd3,  32'h0000_0000, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_0007, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_0070, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_0700, 1'b0, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_0001, 1'b1, 1'b0, NO_PIN},
        '{STEP_ROW, 7'd0,  32'h0000_0000, 1'b1, 1'b1, '{6'd0, 6'd0, 1'b1, 1'b0}}
    };

    logic            clk;
    logic            rst_n     = 1'b0;
    logic            start     = 1'b0;
    logic            busy;
    kwr_in_t         item      = '0;
    logic            result_strobe;
    kwr_out_t        result;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [RC_W-1:0] cfg_data  = '0;

    logic            pin_valid = 1'b0;
    kwr_out_t        pin_value = '0;

    logic [CNT_W-1:0] rank_cnt [STORE_ROWS];
    logic [IDX_W-1:0] rank_idx [STORE_ROWS];
    int               rows_ranked;
    logic             rows_lost;
    logic [RC_W-1:0]  report_k;

    due_t results_due [$];
    due_t head_due;

    int mismatches;
    int results_checked;
    int rows_sent;
    int matrices_closed;
    int overflow_reports;
    int count_writes;
    int cycle_count;
    int idle_pct;

    k_weakest_rows_select u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic check_fields(string tag, kwr_out_t want, kwr_out_t got);
        if (got.row_index !== want.row_index)
        begin
            $error("%s row_index: expected %0d, got %0d", tag, want.row_index, got.row_index);
            mismatches++;
        end
        if (got.soldier_total !== want.soldier_total)
        begin
            $error("%s soldier_total: expected %0d, got %0d", tag, want.soldier_total,
                   got.soldier_total);
            mismatches++;
        end
        if (got.final_result !== want.final_result)
        begin
            $error("%s final_result: expected %0d, got %0d", tag, want.final_result,
                   got.final_result);
            mismatches++;
        end
        if (got.rows_dropped !== want.rows_dropped)
        begin
            $error("%s rows_dropped: expected %0d, got %0d", tag, want.rows_dropped,
                   got.rows_dropped);
            mismatches++;
        end
    endtask

    task automatic rank_row(kwr_in_t row, logic pinned, kwr_out_t pin);
        int   ones;
        int   pos;
        int   n;
        due_t due;
        ones = 0;
        for (int j = 0; j < ROW_W; j++)
            ones += row.row_bits[j];
        if (rows_ranked < STORE_ROWS)
        begin
            pos = rows_ranked;
            while (pos > 0 && rank_cnt[pos-1] > ones)
            begin
                rank_cnt[pos] = rank_cnt[pos-1];
                rank_idx[pos] = rank_idx[pos-1];
                pos--;
            end
            rank_cnt[pos] = ones[CNT_W-1:0];
            rank_idx[pos] = rows_ranked[IDX_W-1:0];
            rows_ranked++;
        end
        else
        begin
            rows_lost = 1'b1;
        end
        if (row.last_row)
        begin
            n = (int'(report_k) < rows_ranked) ? int'(report_k) : rows_ranked;
            for (int k = 0; k < n; k++)
            begin
                due.want.row_index     = rank_idx[k];
                due.want.soldier_total = rank_cnt[k];
                due.want.final_result  = (k == n - 1);
                due.want.rows_dropped  = rows_lost;
                due.pinned             = pinned && (k == 0);
                due.pin                = pin;
                results_due.insert(results_due.size(), due);
            end
            matrices_closed++;
            if (rows_lost)
                overflow_reports++;
            rows_ranked = 0;
            rows_lost   = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: row_index %0d soldier_total %0d",
                           result.row_index, result.soldier_total);
                    mismatches++;
                end
                else
                begin
                    head_due = results_due.pop_front();
                    check_fields("result", head_due.want, result);
                    if (head_due.pinned)
                        check_fields("table result", head_due.pin, result);
                    results_checked++;
                end
            end
            if (start && !busy)
                rank_row(item, pin_valid, pin_value);
            if (cfg_valid && cfg_ready)
                report_k = cfg_data;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("k_weakest_rows_select_tb: done, errors");
            $finish;
        end
    end

    task automatic send_row(logic [31:0] bits, logic last, logic pinned, kwr_out_t pin);
        kwr_in_t row;
        row.row_bits = bits;
        row.last_row = last;
        start     <= 1'b1;
        item      <= row;
        pin_valid <= pinned;
        pin_value <= pin;
        do
            @(posedge clk);
        while (busy);
        rows_sent++;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [RC_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_writes++;
    endtask

    function automatic logic [31:0] random_row();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RC_W-1:0] random_count();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd63;
            default: return 7'($urandom_range(0, 64));
        endcase
    endfunction

    task automatic run_matrix(int length);
        for (int r = 0; r < length; r++)
            send_row(random_row(), r == length - 1, 1'b0, NO_PIN);
    endtask

    initial
    begin
        int phase_start;
        int length;
        rows_ranked = 0;
        rows_lost   = 1'b0;
        report_k    = 7'd1;
        idle_pct    = 15;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == STEP_CFG)
                write_count(DIRECTED[i].count);
            else
                send_row(DIRECTED[i].bits, DIRECTED[i].last, DIRECTED[i].pinned,
                         DIRECTED[i].pin);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 15 : (phase == 1) ? 87 : 0;
            phase_start = rows_sent;
            if (phase == 0)
            begin
                write_count(7'd2);
                run_matrix(STORE_ROWS + 1);
            end
            else if (phase == 2)
            begin
                write_count(7'd64);
                run_matrix(STORE_ROWS + 6);
            end
            write_count(random_count());
            while (rows_sent - phase_start < PHASE_ROWS + ((phase == 1) ? 0 : STORE_ROWS))
            begin
                length = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8);
                run_matrix(length);
                if ($urandom_range(0, 3) == 0)
                    write_count(random_count());
            end
        end

        wait_idle();
        $display("Sent %0d rows in %0d matrices (%0d overflowing the store), %0d register writes.",
                 rows_sent, matrices_closed, overflow_reports, count_writes);
        $display("Checked %0d ranked results under three sender idling profiles.",
                 results_checked);
        if (mismatches == 0)
            $display("k_weakest_rows_select_tb: done, clean");
        else
            $display("k_weakest_rows_select_tb: done, errors");
        $finish;
    end

endmodule
